@@ rtl/bba_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bba_pkg
// Types and constants shared by the free-block bitmap allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int BLOCK_COUNT_DEF = 1024;
    localparam int INDEX_LIMIT     = 1024;
    localparam int BYTE_BITS       = 8;

    typedef enum logic [1:0] {
        REQ_FIND = 2'd0,
        REQ_SET  = 2'd1,
        REQ_TEST = 2'd2
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_RANGE  = 2'd1,
        ST_NOFREE = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [9:0] blk_idx;
        logic       bit_value;
    } bba_req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [9:0] found_index;
        logic       block_free;
    } bba_rsp_t;

    // which result the datapath stages
    typedef enum logic [2:0] {
        RES_OK,
        RES_RANGE,
        RES_TEST,
        RES_FOUND,
        RES_NOFREE
    } res_sel_t;

    typedef struct packed {
        logic     req_load;
        logic     rd_idx;
        logic     rd_scan;
        logic     wr_en;
        logic     res_load;
        res_sel_t res_sel;
        logic     out_load;
    } bba_cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       in_range;
        logic       scan_hit;
        logic       scan_last;
        logic       out_free;
    } bba_sts_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_EVAL,
        S_SCAN,
        S_DONE
    } bba_state_t;

endpackage
`default_nettype wire

@@ rtl/bba_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bba_ctrl
// Request sequencer: decodes a request and steps the datapath through it.
// ----------------------------------------------------------------------------
module bba_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire bba_pkg::bba_sts_t sts,
    output bba_pkg::bba_cmd_t      cmd
);
    import bba_pkg::*;

    bba_state_t state_reg;
    bba_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (sts.req_type == REQ_FIND) begin
                    state_next = S_SCAN;
                end else if ((sts.req_type inside {REQ_SET, REQ_TEST}) && sts.in_range) begin
                    state_next = S_EVAL;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_EVAL: begin
                state_next = S_DONE;
            end
            S_SCAN: begin
                if (sts.scan_hit || sts.scan_last) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        cmd.res_sel = RES_OK;
        s_ready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready      = 1'b1;
                cmd.req_load = s_valid;
            end
            S_DECODE: begin
                if (sts.req_type == REQ_FIND) begin
                    cmd.rd_scan = 1'b1;
                end else if ((sts.req_type inside {REQ_SET, REQ_TEST}) && sts.in_range) begin
                    cmd.rd_idx = 1'b1;
                end else begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_RANGE;
                end
            end
            S_EVAL: begin
                cmd.res_load = 1'b1;
                if (sts.req_type == REQ_SET) begin
                    cmd.wr_en   = 1'b1;
                    cmd.res_sel = RES_OK;
                end else begin
                    cmd.res_sel = RES_TEST;
                end
            end
            S_SCAN: begin
                if (sts.scan_hit) begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_FOUND;
                end else if (sts.scan_last) begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_NOFREE;
                end else begin
                    cmd.rd_scan = 1'b1;
                end
            end
            S_DONE: begin
                cmd.out_load = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/bba_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bba_datapath
// Bitmap memory with per-byte valid bits, scan counter, result staging and
// output register.
// ----------------------------------------------------------------------------
module bba_datapath #(
    parameter int BLOCK_COUNT = bba_pkg::BLOCK_COUNT_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire bba_pkg::bba_req_t s_data,
    input  wire bba_pkg::bba_cmd_t cmd,
    output bba_pkg::bba_sts_t      sts,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output bba_pkg::bba_rsp_t      m_data
);
    import bba_pkg::*;

    // only blocks that a 10-bit index can name are stored
    localparam int LIMIT     = (BLOCK_COUNT < INDEX_LIMIT) ? BLOCK_COUNT : INDEX_LIMIT;
    localparam int DEPTH     = (LIMIT + BYTE_BITS - 1) / BYTE_BITS;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LAST_BITS = LIMIT - (DEPTH - 1) * BYTE_BITS;
    localparam logic [7:0] LAST_MASK = 8'((32'd1 << LAST_BITS) - 32'd1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    logic [7:0]      mem [DEPTH];
    logic            vld_reg [DEPTH];
    logic [7:0]      rdata_reg;
    logic [AW-1:0]   raddr_reg;
    logic [AW-1:0]   scan_cnt_reg;
    bba_req_t        req_reg;
    bba_rsp_t        res_reg;
    bba_rsp_t        res_next;
    bba_rsp_t        out_reg;
    logic            m_valid_reg;

    logic [AW-1:0]   rd_addr;
    logic            rd_en;
    logic [2:0]      bit_sel;
    logic [7:0]      bit_mask;
    logic [7:0]      wdata;
    logic [7:0]      free_bits;
    logic [2:0]      hit_bit;
    logic            out_free;

    assign bit_sel  = req_reg.blk_idx[2:0];
    assign bit_mask = 8'(8'd1 << bit_sel);
    assign wdata    = req_reg.bit_value ? (rdata_reg | bit_mask) : (rdata_reg & ~bit_mask);
    assign rd_en    = cmd.rd_idx || cmd.rd_scan;
    assign rd_addr  = cmd.rd_scan ? scan_cnt_reg : AW'(req_reg.blk_idx[9:3]);

    // free blocks of the byte under evaluation, trimmed at the end of the map
    assign free_bits = ~rdata_reg & ((raddr_reg == LAST_ADDR) ? LAST_MASK : 8'hFF);

    always_comb begin
        hit_bit = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (free_bits[i]) begin
                hit_bit = 3'(i);
            end
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        sts.req_type  = req_reg.req_type;
        sts.in_range  = {22'd0, req_reg.blk_idx} < 32'(BLOCK_COUNT);
        sts.scan_hit  = |free_bits;
        sts.scan_last = (raddr_reg == LAST_ADDR);
        sts.out_free  = out_free;
    end

    // bitmap memory, an unwritten byte reads as all free
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg <= vld_reg[rd_addr] ? mem[rd_addr] : 8'h00;
            raddr_reg <= rd_addr;
        end
        if (cmd.wr_en) begin
            mem[raddr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (cmd.wr_en) begin
            vld_reg[raddr_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.req_load) begin
            req_reg      <= s_data;
            scan_cnt_reg <= '0;
        end else if (cmd.rd_scan) begin
            scan_cnt_reg <= scan_cnt_reg + 1'b1;
        end
    end

    always_comb begin
        res_next = '0;
        case (cmd.res_sel)
            RES_OK: begin
                res_next.status = ST_OK;
            end
            RES_RANGE: begin
                res_next.status = ST_RANGE;
            end
            RES_TEST: begin
                res_next.status     = ST_OK;
                res_next.block_free = ~rdata_reg[bit_sel];
            end
            RES_FOUND: begin
                res_next.status      = ST_OK;
                res_next.found_index = 10'({raddr_reg, hit_bit});
            end
            RES_NOFREE: begin
                res_next.status = ST_NOFREE;
            end
            default: begin
                res_next.status = ST_RANGE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            res_reg <= res_next;
        end
    end

    // output register, the next request may start while a result waits here
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule
`default_nettype wire

@@ rtl/block_bitmap_allocator_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// block_bitmap_allocator_top
// Free-block bitmap allocator: find first free, set or clear, test.
// ----------------------------------------------------------------------------
// One request is in work at a time. A set or test request goes from transfer
// to result by reading the bitmap byte, evaluating it, staging the result and
// loading the output register; an out of range or unknown request skips the
// read and evaluation. A find reads one bitmap byte per cycle through the
// single memory read port, up to ceil(min(BLOCK_COUNT, 1024) / 8) bytes; the
// scan stops at the first byte holding a free block. A result waiting in the
// output register does not hold off the next input transfer. Every block is
// free after reset with no clearing pass, since each bitmap byte carries a
// valid bit cleared by reset.
module block_bitmap_allocator_top #(
    parameter int BLOCK_COUNT = bba_pkg::BLOCK_COUNT_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire bba_pkg::bba_req_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output bba_pkg::bba_rsp_t      m_data
);
    import bba_pkg::*;

    bba_cmd_t cmd;
    bba_sts_t sts;

    bba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bba_datapath #(
        .BLOCK_COUNT (BLOCK_COUNT)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the free-block bitmap allocator. A queue-fed driver
// offers find, set and test requests; a shadow bitmap predicts each response
// and the monitor checks every result transfer against it in order. Phases
// cover directed corners, random traffic on a small window, a full fill in
// shuffled order up to the no-free case, and free/refind cycles on a full map.
// ----------------------------------------------------------------------------
module tb_top;
    import bba_pkg::*;

    localparam int BLOCKS      = BLOCK_COUNT_DEF;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 150;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    bba_req_t s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    bba_rsp_t m_data;

    bba_req_t pending_req_q[$];
    bba_rsp_t expected_rsp_q[$];
    bba_rsp_t exp_rsp;
    logic [BLOCKS-1:0] used_map = '0;

    logic s_taken = 1'b0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_reqs = 0;
    int   hold_seen = 0;
    int   hold_left = 0;
    int   quiet_cycles = 0;
    int   mismatch_count = 0;

    block_bitmap_allocator_top #(
        .BLOCK_COUNT(BLOCKS)
    ) u_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // shadow of the free-block bitmap, advanced once per accepted request
    function automatic bba_rsp_t predict_response(bba_req_t req);
        bba_rsp_t rsp;
        int scan_end;
        int b;
        rsp.status      = ST_RANGE;
        rsp.found_index = '0;
        rsp.block_free  = 1'b0;
        scan_end = (BLOCKS < INDEX_LIMIT) ? BLOCKS : INDEX_LIMIT;
        case (req.req_type)
            REQ_FIND: begin
                rsp.status = ST_NOFREE;
                for (b = 0; b < scan_end && rsp.status != ST_OK; b++) begin
                    if (!used_map[b]) begin
                        rsp.status      = ST_OK;
                        rsp.found_index = 10'(b);
                    end
                end
            end
            REQ_SET: begin
                if (int'(req.blk_idx) < BLOCKS) begin
                    used_map[req.blk_idx] = req.bit_value;
                    rsp.status = ST_OK;
                end
            end
            REQ_TEST: begin
                if (int'(req.blk_idx) < BLOCKS) begin
                    rsp.block_free = !used_map[req.blk_idx];
                    rsp.status     = ST_OK;
                end
            end
            default: begin
            end
        endcase
        return rsp;
    endfunction

    task automatic queue_req(logic [1:0] kind, int idx, bit mark);
        bba_req_t r;
        r.req_type  = kind;
        r.blk_idx   = 10'(idx);
        r.bit_value = mark;
        pending_req_q.push_back(r);
    endtask

    task automatic wait_all_done();
        while (pending_req_q.size() != 0 || s_valid || expected_rsp_q.size() != 0)
            @(negedge aclk);
    endtask

    // request driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (pending_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= pending_req_q.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result-side backpressure, with an occasional long hold
    always @(negedge aclk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // prediction, result check and watchdog
    always @(posedge aclk) begin
        s_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready)
                expected_rsp_q.push_back(predict_response(s_data));
            if (m_valid && m_ready) begin
                if (expected_rsp_q.size() == 0) begin
                    $display("%0t: unexpected result status=%0d found_index=%0d block_free=%0d",
                             $time, m_data.status, m_data.found_index, m_data.block_free);
                    mismatch_count++;
                end else begin
                    exp_rsp = expected_rsp_q.pop_front();
                    if (m_data.status !== exp_rsp.status
                            || m_data.found_index !== exp_rsp.found_index
                            || m_data.block_free !== exp_rsp.block_free) begin
                        $display("%0t: mismatch expected status=%0d found_index=%0d %s%0d",
                                 $time, exp_rsp.status, exp_rsp.found_index,
                                 "block_free=", exp_rsp.block_free);
                        $display("%0t:          actual   status=%0d found_index=%0d %s%0d",
                                 $time, m_data.status, m_data.found_index,
                                 "block_free=", m_data.block_free);
                        mismatch_count++;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                    $display("block_bitmap_allocator_top regression: fail");
                    $finish;
                end
            end
        end
    end

    initial begin
        int order[BLOCKS];
        int n;
        int j;
        int k;
        int idx;
        int roll;

        send_idle_pct = 8;
        recv_idle_pct = 70;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed corners; an out of range index cannot occur at 1024 blocks
        queue_req(REQ_FIND, 1023, 1'b1);
        queue_req(REQ_TEST, 0, 1'b0);
        queue_req(REQ_TEST, 1023, 1'b1);
        queue_req(REQ_SET, 0, 1'b1);
        queue_req(REQ_SET, 1, 1'b1);
        queue_req(REQ_FIND, 0, 1'b0);
        queue_req(REQ_SET, 1023, 1'b1);
        queue_req(REQ_TEST, 1023, 1'b0);
        queue_req(REQ_SET, 1, 1'b0);
        queue_req(REQ_FIND, 1023, 1'b0);
        queue_req(REQ_UNKNOWN, 1023, 1'b1);
        queue_req(REQ_UNKNOWN, 0, 1'b0);
        queue_req(REQ_TEST, 1, 1'b1);
        queue_req(REQ_SET, 512, 1'b1);
        queue_req(REQ_TEST, 512, 1'b0);
        queue_req(REQ_SET, 512, 1'b0);
        queue_req(REQ_SET, 1023, 1'b0);
        queue_req(REQ_SET, 0, 1'b0);
        queue_req(REQ_FIND, 511, 1'b1);
        queue_req(REQ_TEST, 0, 1'b0);

        // random traffic, mostly on a small window so finds land in it
        for (n = 0; n < 200; n++) begin
            roll = $urandom_range(99);
            idx = ($urandom_range(3) == 0) ? $urandom_range(BLOCKS - 1) : $urandom_range(31);
            if (roll < 45)
                queue_req(REQ_SET, idx, $urandom_range(99) < 60);
            else if (roll < 70)
                queue_req(REQ_FIND, $urandom_range(1023), $urandom_range(1));
            else if (roll < 95)
                queue_req(REQ_TEST, idx, $urandom_range(1));
            else
                queue_req(REQ_UNKNOWN, $urandom_range(1023), $urandom_range(1));
        end
        wait_all_done();

        // fill the whole map in shuffled order until nothing is free
        send_idle_pct = 70;
        recv_idle_pct = 8;
        for (n = 0; n < BLOCKS; n++)
            order[n] = n;
        for (n = BLOCKS - 1; n > 0; n--) begin
            j = $urandom_range(n);
            k = order[n];
            order[n] = order[j];
            order[j] = k;
        end
        for (n = 0; n < BLOCKS; n++) begin
            queue_req(REQ_SET, order[n], 1'b1);
            if (n % 16 == 15)
                queue_req(REQ_FIND, $urandom_range(1023), $urandom_range(1));
            if (n % 32 == 7)
                queue_req(REQ_TEST, $urandom_range(BLOCKS - 1), $urandom_range(1));
        end
        queue_req(REQ_FIND, 0, 1'b0);
        queue_req(REQ_TEST, $urandom_range(BLOCKS - 1), 1'b0);
        queue_req(REQ_FIND, 1023, 1'b1);
        // hold the result side while the sender keeps offering
        hold_reqs++;
        wait_all_done();

        // full map: free one block, find it, take it back
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (n = 0; n < 20; n++) begin
            idx = $urandom_range(BLOCKS - 1);
            queue_req(REQ_SET, idx, 1'b0);
            queue_req(REQ_FIND, $urandom_range(1023), $urandom_range(1));
            queue_req(REQ_TEST, idx, $urandom_range(1));
            queue_req(REQ_SET, idx, 1'b1);
        end
        queue_req(REQ_SET, 1023, 1'b0);
        queue_req(REQ_FIND, 0, 1'b0);
        queue_req(REQ_SET, 1023, 1'b1);
        queue_req(REQ_FIND, 0, 1'b0);
        queue_req(REQ_SET, 0, 1'b0);
        queue_req(REQ_FIND, 1023, 1'b1);
        wait_all_done();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("block_bitmap_allocator_top regression: pass");
        end else begin
            $display("block_bitmap_allocator_top regression: fail");
        end
        $finish;
    end

endmodule
